@@ rtl/aett_pkg.sv @@
// shared constants and types for the all-equal tracking table
// no dependencies
package aett_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 8;
  localparam int LEN_W  = 9;
  localparam int SUM_W  = 40;
  localparam int GAP_W  = DATA_W;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // which neighbours of the addressed entry belong to the sequence
  typedef struct packed {
    logic left_ex;
    logic right_ex;
  } nb_t;

endpackage

@@ rtl/all_equal_tracking_table_unit.sv @@
// top level of the all-equal tracking table: entry store, neighbour reads, result register
// depends on aett_pkg and aett_sum_update

// One item is taken at each clock edge where start is high and busy is low; busy is high
// only in the cycle after reset, so a new item may follow in every cycle. The result shows
// on the out_ ports for one cycle under out_strobe; the reads of the entry and both
// neighbours are registered first, then the gap arithmetic and the sum update feed the
// result register. An item that follows a set at the same or a neighbouring index sees the
// new value through a bypass. Writing the length register clears the store at once through
// per-entry valid bits; write it only while no result is pending. Results cannot be held off.
module all_equal_tracking_table_unit import aett_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_op,
  input  logic [IDX_W-1:0]         in_index,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_entry_value,
  output logic                     out_all_equal,
  output logic                     out_out_of_range,
  input  logic                     cfg_we,
  input  logic [LEN_W-1:0]         cfg_wdata
);

  logic [DATA_W-1:0] mem_c [DEPTH];
  logic [DATA_W-1:0] mem_l [DEPTH];
  logic [DATA_W-1:0] mem_p [DEPTH];
  logic [DEPTH-1:0]  vld_r;

  logic              busy_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;

  logic              accept;
  logic [IDX_W-1:0]  idx_m1;
  logic [IDX_W-1:0]  idx_p1;

  logic              ex_vld_r;
  logic              ex_op_r;
  logic [IDX_W-1:0]  ex_idx_r;
  logic signed [DATA_W-1:0] ex_val_r;

  logic [DATA_W-1:0] rd_c_r, rd_l_r, rd_p_r;
  logic              rdv_c_r, rdv_l_r, rdv_p_r;
  logic              fw_c_r, fw_l_r, fw_p_r;
  logic [DATA_W-1:0] fw_val_r;

  logic signed [DATA_W-1:0] cur_c, cur_l, cur_p;
  nb_t               ex_nb;
  logic              ex_bad;
  logic              ex_we;
  logic [LEN_W:0]    idx_next;

  logic              out_strobe_r;
  logic signed [DATA_W-1:0] out_entry_value_r;
  logic              out_all_equal_r;
  logic              out_out_of_range_r;
  logic signed [DATA_W-1:0] shown_nxt;
  logic [SUM_W-1:0]  sum_after;

  assign accept = start && !busy_r;
  assign idx_m1 = in_index - 1'b1;
  assign idx_p1 = in_index + 1'b1;

  // saturate the length into 1..DEPTH
  always_comb begin
    if (cfg_wdata == '0) begin
      len_nxt = LEN_W'(1);
    end else if ({1'b0, cfg_wdata} > (LEN_W+1)'(DEPTH)) begin
      len_nxt = LEN_W'(DEPTH);
    end else begin
      len_nxt = cfg_wdata;
    end
  end

  // execute stage
  always_comb begin
    cur_c = fw_c_r ? fw_val_r : (rdv_c_r ? rd_c_r : '0);
    cur_l = fw_l_r ? fw_val_r : (rdv_l_r ? rd_l_r : '0);
    cur_p = fw_p_r ? fw_val_r : (rdv_p_r ? rd_p_r : '0);
    idx_next       = {2'b00, ex_idx_r} + (LEN_W+1)'(1);
    ex_bad         = {1'b0, ex_idx_r} >= len_r;
    ex_nb.left_ex  = ex_idx_r != '0;
    ex_nb.right_ex = idx_next < {1'b0, len_r};
    ex_we          = ex_vld_r && (ex_op_r == OP_SET) && !ex_bad;
  end

  aett_sum_update u_sum (
    .old_val   (cur_c),
    .new_val   (ex_val_r),
    .left_val  (cur_l),
    .right_val (cur_p),
    .nb        (ex_nb),
    .sum_in    (sum_r),
    .sum_out   (sum_nxt)
  );

  always_comb begin
    sum_after = ex_we ? sum_nxt : sum_r;
    if (ex_bad) begin
      shown_nxt = '0;
    end else if (ex_op_r == OP_SET) begin
      shown_nxt = ex_val_r;
    end else begin
      shown_nxt = cur_c;
    end
  end

  // entry store, one copy per read port
  always_ff @(posedge clk) begin
    if (ex_we) begin
      mem_c[ex_idx_r] <= ex_val_r;
      mem_l[ex_idx_r] <= ex_val_r;
      mem_p[ex_idx_r] <= ex_val_r;
    end
    rd_c_r <= mem_c[in_index];
    rd_l_r <= mem_l[idx_m1];
    rd_p_r <= mem_p[idx_p1];
  end

  // read capture and bypass of the set in flight
  always_ff @(posedge clk) begin
    rdv_c_r  <= vld_r[in_index];
    rdv_l_r  <= vld_r[idx_m1];
    rdv_p_r  <= vld_r[idx_p1];
    fw_c_r   <= ex_we && (ex_idx_r == in_index);
    fw_l_r   <= ex_we && (ex_idx_r == idx_m1);
    fw_p_r   <= ex_we && (ex_idx_r == idx_p1);
    fw_val_r <= ex_val_r;
    ex_op_r  <= in_op;
    ex_idx_r <= in_index;
    ex_val_r <= in_value;
    out_entry_value_r  <= shown_nxt;
    out_all_equal_r    <= sum_after == '0;
    out_out_of_range_r <= ex_bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      len_r        <= LEN_W'(DEPTH);
      sum_r        <= '0;
      vld_r        <= '0;
      ex_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      ex_vld_r     <= accept;
      out_strobe_r <= ex_vld_r;
      if (cfg_we) begin
        len_r <= len_nxt;
        sum_r <= '0;
        vld_r <= '0;
      end else if (ex_we) begin
        sum_r           <= sum_nxt;
        vld_r[ex_idx_r] <= 1'b1;
      end
    end
  end

  assign busy             = busy_r;
  assign out_strobe       = out_strobe_r;
  assign out_entry_value  = out_entry_value_r;
  assign out_all_equal    = out_all_equal_r;
  assign out_out_of_range = out_out_of_range_r;

  a_beat_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("beat did not produce a result two cycles later");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_out_of_range) |-> (out_entry_value == '0))
    else $error("out of range result carries a nonzero value");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (sum_r == '0) && (vld_r == '0))
    else $error("length write did not clear the store");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) && ({1'b0, len_r} <= (LEN_W+1)'(DEPTH)))
    else $error("length outside its range");

endmodule

@@ rtl/aett_sum_update.sv @@
// difference sum update for one set: drops the old neighbour gaps, adds the new ones
// depends on aett_pkg
module aett_sum_update import aett_pkg::*; (
  input  logic signed [DATA_W-1:0] old_val,
  input  logic signed [DATA_W-1:0] new_val,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic signed [DATA_W-1:0] right_val,
  input  nb_t                      nb,
  input  logic [SUM_W-1:0]         sum_in,
  output logic [SUM_W-1:0]         sum_out
);

  logic [GAP_W-1:0] gl_old;
  logic [GAP_W-1:0] gr_old;
  logic [GAP_W-1:0] gl_new;
  logic [GAP_W-1:0] gr_new;
  logic [GAP_W:0]   old_pair;
  logic [GAP_W:0]   new_pair;

  function automatic logic [GAP_W-1:0] abs_gap(input logic signed [DATA_W-1:0] a,
                                               input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    logic [DATA_W:0]        m;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    m = d[DATA_W] ? (~d + 1'b1) : d;
    return m[GAP_W-1:0];
  endfunction

  always_comb begin
    gl_old   = nb.left_ex  ? abs_gap(old_val, left_val)  : '0;
    gr_old   = nb.right_ex ? abs_gap(old_val, right_val) : '0;
    gl_new   = nb.left_ex  ? abs_gap(new_val, left_val)  : '0;
    gr_new   = nb.right_ex ? abs_gap(new_val, right_val) : '0;
    old_pair = {1'b0, gl_old} + {1'b0, gr_old};
    new_pair = {1'b0, gl_new} + {1'b0, gr_new};
    sum_out  = sum_in - {{(SUM_W-GAP_W-1){1'b0}}, old_pair}
                      + {{(SUM_W-GAP_W-1){1'b0}}, new_pair};
  end

endmodule
